FILE: design/csa_pkg.sv
// shared types and codes for the consensus acceptor
// no dependencies; imported by every module of the block
package csa_pkg;

    // default number of committed-value slots
    localparam int unsigned VALUE_SLOTS_DEF = 256;

    // message kinds
    localparam logic [1:0] CMD_PREPARE = 2'd0;
    localparam logic [1:0] CMD_ACCEPT  = 2'd1;
    localparam logic [1:0] CMD_DECIDE  = 2'd2;

    // register map, one 64-bit register every 8 bytes
    localparam int REG_IDX_W = 2;
    localparam int APB_AW    = REG_IDX_W + 3;
    localparam logic [REG_IDX_W-1:0] REG_OWN_NODE_ID     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_COMMITTED = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_VALUE   = 2'd2;

    typedef struct packed {
        logic [15:0] own_node_id;
        logic        start_committed;
        logic [63:0] initial_value;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] request_instance;
        logic [31:0] request_round;
        logic [15:0] request_node;
        logic [63:0] request_value;
    } req_t;

    typedef struct packed {
        logic        granted;
        logic        stale;
        logic [31:0] reply_round;
        logic [15:0] reply_node;
        logic [63:0] reply_value;
        logic        reply_value_valid;
        logic        committed;
        logic [31:0] commit_instance;
        logic [63:0] commit_value;
    } res_t;

endpackage

FILE: design/csa_regs.sv
// configuration registers behind the apb port
// depends on csa_pkg; raises a one-cycle init request after each register write
module csa_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [csa_pkg::APB_AW-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    output csa_pkg::cfg_t              cfg,
    output logic                       init
);
    import csa_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    logic                 init_reg, init_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:3];

    // register write decode
    always_comb begin
        cfg_next  = cfg_reg;
        init_next = 1'b0;
        if (wr_en) begin
            case (reg_idx)
                REG_OWN_NODE_ID: begin
                    cfg_next.own_node_id = pwdata[15:0];
                    init_next            = 1'b1;
                end
                REG_START_COMMITTED: begin
                    cfg_next.start_committed = pwdata[0];
                    init_next                = 1'b1;
                end
                REG_INITIAL_VALUE: begin
                    cfg_next.initial_value = pwdata;
                    init_next              = 1'b1;
                end
                default: begin
                    init_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg  <= '0;
            init_reg <= 1'b0;
        end else begin
            cfg_reg  <= cfg_next;
            init_reg <= init_next;
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_OWN_NODE_ID:     prdata = {48'd0, cfg_reg.own_node_id};
            REG_START_COMMITTED: prdata = {63'd0, cfg_reg.start_committed};
            REG_INITIAL_VALUE:   prdata = cfg_reg.initial_value;
            default:             prdata = '0;
        endcase
    end

    assign cfg  = cfg_reg;
    assign init = init_reg;

endmodule

FILE: design/csa_slot.sv
// table slot of a message: instance modulo the slot count
// depends on csa_pkg; a mask for a power-of-two count, else a three-stage reciprocal pipeline
module csa_slot #(
    parameter int unsigned VALUE_SLOTS = csa_pkg::VALUE_SLOTS_DEF,
    localparam int SLOT_W = $clog2(VALUE_SLOTS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  csa_pkg::req_t     in_req,
    output logic              out_valid,
    output csa_pkg::req_t     out_req,
    output logic [SLOT_W-1:0] out_slot
);
    import csa_pkg::*;

    localparam bit POW2 = ((VALUE_SLOTS & (VALUE_SLOTS - 1)) == 0);

    generate
        if (POW2) begin : g_mask
            // low bits of the instance, combinational
            assign out_valid = in_valid;
            assign out_req   = in_req;
            assign out_slot  = in_req.request_instance[SLOT_W-1:0];
        end else begin : g_recip
            // q estimate from floor(2^32 / n), off by at most one
            localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / VALUE_SLOTS);
            localparam logic [31:0] SLOTS32 = 32'(VALUE_SLOTS);

            logic [2:0]        v_reg;
            req_t              r1_reg, r2_reg, r3_reg;
            logic [31:0]       q1_reg, qn2_reg;
            logic [SLOT_W-1:0] slot3_reg;
            logic [63:0]       prod1, prod2;
            logic [31:0]       rem_raw, rem_fix;

            assign prod1   = 64'(in_req.request_instance) * 64'(RECIP);
            assign prod2   = 64'(q1_reg) * 64'(SLOTS32);
            assign rem_raw = r2_reg.request_instance - qn2_reg;
            // remainder estimate is below twice the count
            assign rem_fix = (rem_raw >= SLOTS32) ? (rem_raw - SLOTS32) : rem_raw;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg <= '0;
                end else if (en) begin
                    v_reg <= {v_reg[1:0], in_valid};
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    r1_reg    <= in_req;
                    q1_reg    <= prod1[63:32];
                    r2_reg    <= r1_reg;
                    qn2_reg   <= prod2[31:0];
                    r3_reg    <= r2_reg;
                    slot3_reg <= rem_fix[SLOT_W-1:0];
                end
            end

            assign out_valid = v_reg[2];
            assign out_req   = r3_reg;
            assign out_slot  = slot3_reg;
        end
    endgenerate

endmodule

FILE: design/csa_table.sv
// committed-value table: one write port, one registered read port, clearing sweep
// depends on csa_pkg; the read forwards a write made at the same edge to the same slot
module csa_table #(
    parameter int unsigned VALUE_SLOTS = csa_pkg::VALUE_SLOTS_DEF,
    localparam int SLOT_W = $clog2(VALUE_SLOTS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              init,
    input  csa_pkg::cfg_t     cfg,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic [63:0]       wr_data,
    output logic              rd_present,
    output logic [63:0]       rd_value,
    output logic              busy
);
    import csa_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VALUE_SLOTS - 1);
    localparam logic [SLOT_W-1:0] INIT_SLOT = SLOT_W'(1);

    // entry is {present, value}
    logic [64:0]       mem [VALUE_SLOTS];
    logic [64:0]       rd_reg;
    logic              byp_reg;
    logic [63:0]       byp_data_reg;
    logic              clr_reg, clr_next;
    logic [SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    logic [64:0]       mem_wd;
    logic              fill_present;

    // clearing sweep, restarted by every init request
    always_comb begin
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        if (init) begin
            clr_next     = 1'b1;
            clr_cnt_next = '0;
        end else if (clr_reg) begin
            if (clr_cnt_reg == LAST_SLOT) begin
                clr_next = 1'b0;
            end else begin
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else begin
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // write port shared by the sweep and decides
    assign fill_present = cfg.start_committed && (clr_cnt_reg == INIT_SLOT);
    assign mem_we       = clr_reg || wr_en;
    assign mem_wa       = clr_reg ? clr_cnt_reg : wr_addr;
    assign mem_wd       = clr_reg ? {fill_present, cfg.initial_value} : {1'b1, wr_data};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // forwarding of a same-edge write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            byp_data_reg <= wr_data;
        end
    end

    assign rd_present = byp_reg || rd_reg[64];
    assign rd_value   = byp_reg ? byp_data_reg : rd_reg[63:0];
    assign busy       = clr_reg || init;

endmodule

FILE: design/csa_core.sv
// acceptor state and per-message decision
// depends on csa_pkg; state advances only when a word leaves the decision stage
module csa_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          init,
    input  csa_pkg::cfg_t cfg,
    input  logic          fire,
    input  csa_pkg::req_t req,
    input  logic          rd_present,
    input  logic [63:0]   rd_value,
    output csa_pkg::res_t res
);
    import csa_pkg::*;

    logic [31:0] highest_reg, highest_next;
    logic [31:0] prom_round_reg, prom_round_next;
    logic [15:0] prom_node_reg, prom_node_next;
    logic [31:0] acc_round_reg, acc_round_next;
    logic [15:0] acc_node_reg, acc_node_next;
    logic [63:0] acc_value_reg, acc_value_next;
    logic        acc_present_reg, acc_present_next;
    logic        stale;
    logic        prep_ok;
    logic        acc_ok;

    assign stale   = req.request_instance <= highest_reg;
    // proposal order: round first, node id second
    assign prep_ok = (req.request_round > prom_round_reg)
                  || ((req.request_round == prom_round_reg)
                      && (req.request_node > prom_node_reg));
    assign acc_ok  = (req.request_round > prom_round_reg)
                  || ((req.request_round == prom_round_reg)
                      && (req.request_node >= prom_node_reg));

    // decision and next state
    always_comb begin
        highest_next     = highest_reg;
        prom_round_next  = prom_round_reg;
        prom_node_next   = prom_node_reg;
        acc_round_next   = acc_round_reg;
        acc_node_next    = acc_node_reg;
        acc_value_next   = acc_value_reg;
        acc_present_next = acc_present_reg;
        res              = '0;
        case (req.cmd)
            CMD_PREPARE: begin
                if (stale) begin
                    res.stale             = 1'b1;
                    res.reply_value_valid = rd_present;
                    res.reply_value       = rd_present ? rd_value : 64'd0;
                end else if (prep_ok) begin
                    prom_round_next       = req.request_round;
                    prom_node_next        = req.request_node;
                    res.granted           = 1'b1;
                    res.reply_round       = acc_round_reg;
                    res.reply_node        = acc_node_reg;
                    res.reply_value_valid = acc_present_reg;
                    res.reply_value       = acc_present_reg ? acc_value_reg : 64'd0;
                end
            end
            CMD_ACCEPT: begin
                if (stale) begin
                    res.stale = 1'b1;
                end else if (acc_ok) begin
                    acc_round_next   = req.request_round;
                    acc_node_next    = req.request_node;
                    acc_value_next   = req.request_value;
                    acc_present_next = 1'b1;
                    res.granted      = 1'b1;
                end
            end
            CMD_DECIDE: begin
                if (stale) begin
                    res.stale = 1'b1;
                end else begin
                    highest_next        = req.request_instance;
                    prom_round_next     = '0;
                    prom_node_next      = cfg.own_node_id;
                    acc_round_next      = '0;
                    acc_node_next       = cfg.own_node_id;
                    acc_value_next      = '0;
                    acc_present_next    = 1'b0;
                    res.committed       = 1'b1;
                    res.commit_instance = req.request_instance;
                    res.commit_value    = req.request_value;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // state registers, re-initialized from the registers on init
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            highest_reg     <= '0;
            prom_round_reg  <= '0;
            prom_node_reg   <= '0;
            acc_round_reg   <= '0;
            acc_node_reg    <= '0;
            acc_value_reg   <= '0;
            acc_present_reg <= 1'b0;
        end else if (init) begin
            highest_reg     <= {31'd0, cfg.start_committed};
            prom_round_reg  <= '0;
            prom_node_reg   <= cfg.own_node_id;
            acc_round_reg   <= '0;
            acc_node_reg    <= cfg.own_node_id;
            acc_value_reg   <= '0;
            acc_present_reg <= 1'b0;
        end else if (fire) begin
            highest_reg     <= highest_next;
            prom_round_reg  <= prom_round_next;
            prom_node_reg   <= prom_node_next;
            acc_round_reg   <= acc_round_next;
            acc_node_reg    <= acc_node_next;
            acc_value_reg   <= acc_value_next;
            acc_present_reg <= acc_present_next;
        end
    end

endmodule

FILE: design/consensus_acceptor.sv
// Consensus acceptor: takes one prepare, accept or decide word per cycle while s_ready is
// high and returns exactly one result word for each, in order. Each word passes through
// the decision stage and result registers, after three extra stages that compute instance
// modulo VALUE_SLOTS by reciprocal multiplication when VALUE_SLOTS is not a power of
// two; the rate is one word per cycle either way, set by the single decision stage and
// the one-read, one-write committed-value memory. After reset and after each write to
// own_node_id, start_committed or initial_value, the memory is swept one slot per cycle
// with s_ready low; registers may be written during the sweep, which then starts over.
// Registers sit at byte addresses 0, 8 and 16 of a 64-bit apb port.
// Depends on csa_pkg, csa_regs, csa_slot, csa_table and csa_core.
module consensus_acceptor #(
    parameter int unsigned VALUE_SLOTS = csa_pkg::VALUE_SLOTS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [csa_pkg::APB_AW-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic [31:0]                s_request_instance,
    input  logic [31:0]                s_request_round,
    input  logic [15:0]                s_request_node,
    input  logic [63:0]                s_request_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_granted,
    output logic                       m_stale,
    output logic [31:0]                m_reply_round,
    output logic [15:0]                m_reply_node,
    output logic [63:0]                m_reply_value,
    output logic                       m_reply_value_valid,
    output logic                       m_committed,
    output logic [31:0]                m_commit_instance,
    output logic [63:0]                m_commit_value
);
    import csa_pkg::*;

    localparam int SLOT_W = $clog2(VALUE_SLOTS);

    cfg_t              cfg;
    logic              init;
    logic              busy;
    logic              en;
    logic              s_fire;
    req_t              s_req;
    logic              f_valid;
    req_t              f_req;
    logic [SLOT_W-1:0] f_slot;
    logic              a_valid_reg;
    req_t              a_req_reg;
    logic [SLOT_W-1:0] a_slot_reg;
    logic              a_fire;
    res_t              a_res;
    logic              rd_present;
    logic [63:0]       rd_value;
    logic              m_valid_reg;
    res_t              m_res_reg;

    csa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .init    (init)
    );

    // whole pipeline moves when the result register is free or being taken
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en && !busy;
    assign s_fire  = s_valid && s_ready;

    assign s_req.cmd              = s_cmd;
    assign s_req.request_instance = s_request_instance;
    assign s_req.request_round    = s_request_round;
    assign s_req.request_node     = s_request_node;
    assign s_req.request_value    = s_request_value;

    csa_slot #(.VALUE_SLOTS(VALUE_SLOTS)) u_slot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_fire),
        .in_req    (s_req),
        .out_valid (f_valid),
        .out_req   (f_req),
        .out_slot  (f_slot)
    );

    // decision stage register, table read issued as a word enters it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= f_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_req_reg  <= f_req;
            a_slot_reg <= f_slot;
        end
    end

    assign a_fire = a_valid_reg && en;

    csa_table #(.VALUE_SLOTS(VALUE_SLOTS)) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .init       (init),
        .cfg        (cfg),
        .rd_en      (en && f_valid),
        .rd_addr    (f_slot),
        .wr_en      (a_fire && a_res.committed),
        .wr_addr    (a_slot_reg),
        .wr_data    (a_req_reg.request_value),
        .rd_present (rd_present),
        .rd_value   (rd_value),
        .busy       (busy)
    );

    csa_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .init       (init),
        .cfg        (cfg),
        .fire       (a_fire),
        .req        (a_req_reg),
        .rd_present (rd_present),
        .rd_value   (rd_value),
        .res        (a_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire) begin
            m_res_reg <= a_res;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_granted           = m_res_reg.granted;
    assign m_stale             = m_res_reg.stale;
    assign m_reply_round       = m_res_reg.reply_round;
    assign m_reply_node        = m_res_reg.reply_node;
    assign m_reply_value       = m_res_reg.reply_value;
    assign m_reply_value_valid = m_res_reg.reply_value_valid;
    assign m_committed         = m_res_reg.committed;
    assign m_commit_instance   = m_res_reg.commit_instance;
    assign m_commit_value      = m_res_reg.commit_value;

endmodule
